@@ rtl/core/owm_pkg.sv @@
`timescale 1ns / 1ps
package owm_pkg;
  localparam int GAIN_W = 12;
  localparam int HV_W = 10;
  localparam int CORR_W = 16;
  localparam int DIR_W = 9;
  localparam int PWR_W = 8;
  localparam int BYTE_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam logic [1:0] KIND_GYRO = 2'd0;
  localparam logic [1:0] KIND_CAM = 2'd1;
  localparam logic [1:0] KIND_MOVE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_D = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_P = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_D = 2'd3;
  localparam logic [5:0] ASCII_ZERO = 6'd48;

  typedef enum logic [3:0] {
    ST_IDLE, ST_HEAD, ST_SIN, ST_MAX, ST_NUM, ST_DIV, ST_DIGIT, ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic head;
    logic sin_step;
    logic num;
    logic max_load;
    logic digit;
    logic emit_next;
  } cmd_t;

  typedef struct packed {
    logic is_head;
    logic is_move;
    logic sin_done;
    logic div_done;
    logic frame_last;
    logic wheel_last;
  } stat_t;
endpackage

@@ rtl/core/owm_if.sv @@
`timescale 1ns / 1ps
interface owm_in_if;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic signed [9:0] heading_value;
  logic [11:0] p_gain_override;
  logic [11:0] d_gain_override;
  logic [8:0] move_direction;
  logic signed [7:0] move_power;
  modport source(output valid, kind, heading_value, p_gain_override, d_gain_override,
    move_direction, move_power, input ready);
  modport sink(input valid, kind, heading_value, p_gain_override, d_gain_override,
    move_direction, move_power, output ready);
endinterface

interface owm_out_if;
  logic valid;
  logic ready;
  logic [5:0] frame_byte;
  logic last_byte;
  modport source(output valid, frame_byte, last_byte, input ready);
  modport sink(input valid, frame_byte, last_byte, output ready);
endinterface

interface owm_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [11:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/core/owm_ctrl.sv @@
`timescale 1ns / 1ps
module owm_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output owm_pkg::cmd_t cmd,
  input  owm_pkg::stat_t stat
);
  owm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= owm_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      owm_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (stat.is_head) state_nxt = owm_pkg::ST_HEAD;
          else if (stat.is_move) state_nxt = owm_pkg::ST_SIN;
        end
      end
      owm_pkg::ST_HEAD: state_nxt = owm_pkg::ST_IDLE;
      owm_pkg::ST_SIN: if (stat.sin_done) state_nxt = owm_pkg::ST_MAX;
      owm_pkg::ST_MAX: state_nxt = owm_pkg::ST_NUM;
      owm_pkg::ST_NUM: state_nxt = owm_pkg::ST_DIV;
      owm_pkg::ST_DIV: if (stat.div_done) state_nxt = owm_pkg::ST_DIGIT;
      owm_pkg::ST_DIGIT: state_nxt = owm_pkg::ST_EMIT;
      owm_pkg::ST_EMIT: begin
        if (out_ready) begin
          if (stat.frame_last) state_nxt = owm_pkg::ST_IDLE;
          else if (stat.wheel_last) state_nxt = owm_pkg::ST_NUM;
        end
      end
      default: state_nxt = owm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      owm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      owm_pkg::ST_HEAD: cmd.head = 1'b1;
      owm_pkg::ST_SIN: cmd.sin_step = 1'b1;
      owm_pkg::ST_MAX: cmd.max_load = 1'b1;
      owm_pkg::ST_NUM: cmd.num = 1'b1;
      owm_pkg::ST_DIV: cmd.num = 1'b0;
      owm_pkg::ST_DIGIT: cmd.digit = 1'b1;
      owm_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        cmd.emit_next = out_ready;
      end
      default: cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != owm_pkg::ST_IDLE |-> !in_ready) else $error("ready while busy");
  a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == owm_pkg::ST_EMIT) else $error("stray out valid");
  a_head_return: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == owm_pkg::ST_HEAD |=> state_r == owm_pkg::ST_IDLE) else $error("head stuck");
`endif
endmodule

@@ rtl/core/owm_dp.sv @@
`timescale 1ns / 1ps
module owm_dp #(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int SINE_FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst_n,
  input  logic [1:0] kind,
  input  logic signed [9:0] heading_value,
  input  logic [11:0] p_gain_override,
  input  logic [11:0] d_gain_override,
  input  logic [8:0] move_direction,
  input  logic signed [7:0] move_power,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [11:0] cfg_data,
  input  owm_pkg::cmd_t cmd,
  output owm_pkg::stat_t stat,
  output logic [5:0] frame_byte,
  output logic last_byte
);
  localparam int SW = SINE_FRAC_BITS + 2;
  localparam int NW = SW + 8 + 2;
  localparam int QW = NW + 1;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // quarter-wave sine, evaluated at elaboration only
  function automatic logic [SW-1:0] qsin(input int k);
    longint unsigned x, term;
    longint sum;
    x = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    return SW'((sum + (64'sd1 <<< (29 - SINE_FRAC_BITS))) >>> (30 - SINE_FRAC_BITS));
  endfunction

  logic [SW-1:0] qtab [0:90];

  for (genvar g = 0; g <= 90; g++) begin : g_qtab
    localparam logic [SW-1:0] QV = qsin(g);
    assign qtab[g] = QV;
  end

  logic [11:0] gp_r, gd_r, cp_r, cd_r;
  logic signed [9:0] prev_r;
  logic signed [15:0] corr_r;
  logic [1:0] kind_r;
  logic signed [9:0] hv_r;
  logic [11:0] pov_r, dov_r;
  logic [8:0] dir_r;
  logic [7:0] mag_r;
  logic [1:0] idx_r;
  logic signed [SW:0] s_r [3];
  logic [SW-1:0] m_r;
  logic [9:0] ang;
  logic [6:0] qa;
  logic [SW-1:0] qv;
  logic signed [SW:0] sv;
  logic signed [10:0] err;
  logic [11:0] pg, dg;
  logic signed [26:0] acc;
  logic signed [26:0] qt;
  logic signed [NW+16:0] num_r;
  logic neg_r;
  logic sat_r;
  logic [NW+16:0] rem_r, dvs_r;
  logic [NW+16:0] num_abs, lim100;
  logic [7:0] quo_r;
  logic [3:0] dcnt_r;
  logic [6:0] w_r;
  logic wneg_r;
  logic [3:0] bytes_r;
  logic [1:0] bcnt_r;
  logic [3:0] hund, tens, ones;
  logic [6:0] low2;
  logic [14:0] t_prod;
  logic [SW-1:0] a0, a1, a2, mx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_r <= 12'd128; gd_r <= 12'd384; cp_r <= 12'd422; cd_r <= 12'd538;
      prev_r <= '0; corr_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          owm_pkg::REG_GYRO_P: gp_r <= cfg_data;
          owm_pkg::REG_GYRO_D: gd_r <= cfg_data;
          owm_pkg::REG_CAM_P: cp_r <= cfg_data;
          owm_pkg::REG_CAM_D: cd_r <= cfg_data;
          default: gp_r <= gp_r;
        endcase
      end
      if (cmd.head) begin
        prev_r <= err[9:0];
        if (qt > 27'sd32767) corr_r <= 16'sd32767;
        else if (qt < -27'sd32768) corr_r <= -16'sd32768;
        else corr_r <= qt[15:0];
      end
    end
  end

  always_comb begin
    err = 11'(hv_r);
    pg = gp_r; dg = gd_r;
    if (kind_r == owm_pkg::KIND_CAM) begin
      if (hv_r >= 10'sd90) err = 11'(hv_r) - 11'sd180;
      pg = (pov_r != 0) ? pov_r : cp_r;
      dg = (dov_r != 0) ? dov_r : cd_r;
    end
    acc = 27'(err) * $signed({1'b0, pg}) + 27'(err - 11'(prev_r)) * $signed({1'b0, dg});
    qt = (acc < 0) ? -((-acc) >>> GAIN_FRAC_BITS) : (acc >>> GAIN_FRAC_BITS);
  end

  always_comb begin
    unique case (idx_r)
      2'd0: ang = {1'b0, dir_r} + 10'd60;
      2'd1: ang = {1'b0, dir_r} + 10'd300;
      default: ang = {1'b0, dir_r} + 10'd180;
    endcase
    if (ang >= 10'd360) ang = ang - 10'd360;
    if (ang <= 10'd90) qa = ang[6:0];
    else if (ang <= 10'd180) qa = 7'(10'd180 - ang);
    else if (ang <= 10'd270) qa = 7'(ang - 10'd180);
    else qa = 7'(10'd360 - ang);
    qv = qtab[qa];
    sv = (ang <= 10'd180) ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
    a0 = s_r[0][SW] ? SW'(-s_r[0]) : SW'(s_r[0]);
    a1 = s_r[1][SW] ? SW'(-s_r[1]) : SW'(s_r[1]);
    a2 = s_r[2][SW] ? SW'(-s_r[2]) : SW'(s_r[2]);
    mx = a0;
    if (a1 > mx) mx = a1;
    if (a2 > mx) mx = a2;
    if (mx == 0) mx = SW'(1);
    num_abs = num_r[NW+16] ? (NW+17)'(-num_r) : (NW+17)'(num_r);
    lim100 = ((NW+17)'(m_r) << 6) + ((NW+17)'(m_r) << 5) + ((NW+17)'(m_r) << 2);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind; hv_r <= heading_value; pov_r <= p_gain_override;
      dov_r <= d_gain_override;
      dir_r <= (move_direction >= 9'd360) ? move_direction - 9'd360 : move_direction;
      mag_r <= move_power[7] ? 8'(-move_power) : 8'(move_power);
      idx_r <= '0; bytes_r <= '0; bcnt_r <= '0;
    end
    if (cmd.sin_step) begin
      s_r[idx_r] <= sv;
      idx_r <= (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
    end
    if (cmd.max_load) m_r <= mx;
    if (cmd.num) begin
      num_r <= (NW+17)'(s_r[idx_r]) * $signed({1'b0, mag_r})
             - (NW+17)'(corr_r) * $signed({1'b0, m_r});
      dcnt_r <= 4'd8;
      quo_r <= '0;
    end else if (dcnt_r != 0) begin
      if (dcnt_r == 4'd8) begin
        neg_r <= num_r[NW+16];
        rem_r <= num_abs;
        sat_r <= (num_abs >= lim100);
        dvs_r <= (NW+17)'(m_r) << 6;
        quo_r <= '0;
        dcnt_r <= 4'd7;
      end else begin
        if (rem_r >= dvs_r) begin
          rem_r <= rem_r - dvs_r;
          quo_r <= {quo_r[6:0], 1'b1};
        end else quo_r <= {quo_r[6:0], 1'b0};
        dvs_r <= dvs_r >> 1;
        dcnt_r <= dcnt_r - 4'd1;
      end
    end
    if (cmd.digit) begin
      w_r <= sat_r ? 7'd100 : quo_r[6:0];
      wneg_r <= neg_r && (sat_r || (quo_r != 8'd0));
    end
    if (cmd.emit_next) begin
      bytes_r <= bytes_r + 4'd1;
      bcnt_r <= bcnt_r + 2'd1;
      if (bcnt_r == 2'd3) idx_r <= idx_r + 2'd1;
    end
  end

  always_comb begin
    hund = (w_r >= 7'd100) ? 4'd1 : 4'd0;
    low2 = (w_r >= 7'd100) ? w_r - 7'd100 : w_r;
    // divide by ten through reciprocal multiply, exact for every 7-bit low2
    t_prod = 15'(low2) * 15'd205;
    tens = 4'(t_prod >> 11);
    ones = 4'(low2 - ({3'd0, tens} << 3) - ({3'd0, tens} << 1));
    unique case (bcnt_r)
      2'd0: frame_byte = owm_pkg::ASCII_ZERO + {5'd0, wneg_r};
      2'd1: frame_byte = owm_pkg::ASCII_ZERO + {2'd0, hund};
      2'd2: frame_byte = owm_pkg::ASCII_ZERO + {2'd0, tens};
      default: frame_byte = owm_pkg::ASCII_ZERO + {2'd0, ones};
    endcase
    last_byte = (bytes_r == 4'd11);
    stat.is_head = (kind == owm_pkg::KIND_GYRO) || (kind == owm_pkg::KIND_CAM);
    stat.is_move = (kind == owm_pkg::KIND_MOVE);
    stat.sin_done = (idx_r == 2'd2);
    stat.div_done = (dcnt_r == 4'd1);
    stat.frame_last = (bytes_r == 4'd11);
    stat.wheel_last = (bcnt_r == 2'd3);
  end
endmodule

@@ rtl/core/omni_wheel_mixer_pd_heading.sv @@
`timescale 1ns / 1ps
// channel | dir | payload
// in_     | in  | kind, heading_value, gains, move_direction, move_power
// out_    | out | frame_byte, last_byte (twelve per move)
// cfg_    | in  | index, data
// heading items pass through the head state only; output stalls can lengthen a move
// per wheel: setup, a divider setup step and a 7-step restoring divide,
// digit split and four bytes
// rst_n synchronous, restores default gains and clears heading state
// out_ stall holds the current byte; no new item is taken until a frame ends
module omni_wheel_mixer_pd_heading #(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int SINE_FRAC_BITS = 14
) (
  input logic clk,
  input logic rst_n,
  owm_in_if.sink in_ch,
  owm_out_if.source out_ch,
  owm_cfg_if.sink cfg_ch
);
  owm_pkg::cmd_t cmd;
  owm_pkg::stat_t stat;

  assign cfg_ch.ready = 1'b1;

  owm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd(cmd), .stat(stat)
  );

  owm_dp #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS), .SINE_FRAC_BITS(SINE_FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .kind(in_ch.kind), .heading_value(in_ch.heading_value),
    .p_gain_override(in_ch.p_gain_override), .d_gain_override(in_ch.d_gain_override),
    .move_direction(in_ch.move_direction), .move_power(in_ch.move_power),
    .cfg_we(cfg_ch.valid), .cfg_index(cfg_ch.index), .cfg_data(cfg_ch.data),
    .cmd(cmd), .stat(stat), .frame_byte(out_ch.frame_byte), .last_byte(out_ch.last_byte)
  );
endmodule

@@ test/owm_frame_checker.sv @@
`timescale 1ns / 1ps
module owm_frame_checker (
  input logic clk,
  input logic rst_n,
  owm_in_if in_ch,
  owm_out_if out_ch,
  owm_cfg_if cfg_ch,
  output int errors,
  output int pending
);
  localparam int GAIN_FRAC = 8;
  localparam int SINE_FRAC = 14;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic [owm_pkg::BYTE_W-1:0] frame_byte;
    logic last_byte;
  } frame_byte_t;

  logic [owm_pkg::GAIN_W-1:0] gyro_p, gyro_d, cam_p, cam_d;
  int prev_dev;
  int correction;
  int sine_q[0:359];
  frame_byte_t frame_q[$];

  function automatic longint quarter_wave(int unsigned k);
    longint unsigned x, term;
    longint acc;
    x = (longint'(k) * PI_Q30 + 90) / 180;
    term = x;
    acc = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    return (acc + (longint'(1) << (29 - SINE_FRAC))) >>> (30 - SINE_FRAC);
  endfunction

  initial begin
    for (int a = 0; a < 360; a++) begin
      if (a <= 90) sine_q[a] = int'(quarter_wave(a));
      else if (a <= 180) sine_q[a] = int'(quarter_wave(180 - a));
      else if (a <= 270) sine_q[a] = -int'(quarter_wave(a - 180));
      else sine_q[a] = -int'(quarter_wave(360 - a));
    end
  end

  function automatic int heading_pd(int err, int pg, int dg);
    longint acc;
    longint q;
    acc = longint'(err) * pg + longint'(err - prev_dev) * dg;
    q = acc / (longint'(1) << GAIN_FRAC);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    prev_dev = err;
    return int'(q);
  endfunction

  task automatic mix_wheels(int dir_in, int pw);
    longint s[3];
    longint m, mag, num, w, u;
    int dir;
    dir = dir_in % 360;
    s[0] = -sine_q[(dir + 60) % 360];
    s[1] = -sine_q[(dir + 300) % 360];
    s[2] = -sine_q[(dir + 180) % 360];
    m = 0;
    for (int k = 0; k < 3; k++) if ((s[k] < 0 ? -s[k] : s[k]) > m) m = s[k] < 0 ? -s[k] : s[k];
    if (m == 0) m = 1;
    mag = pw < 0 ? -pw : pw;
    for (int k = 0; k < 3; k++) begin
      num = s[k] * mag - longint'(correction) * m;
      if (num > 100 * m) w = 100;
      else if (num < -100 * m) w = -100;
      else w = num / m;
      u = w < 0 ? -w : w;
      frame_q.push_back('{w < 0 ? owm_pkg::ASCII_ZERO + 6'd1 : owm_pkg::ASCII_ZERO, 1'b0});
      frame_q.push_back('{owm_pkg::ASCII_ZERO + 6'(u / 100), 1'b0});
      frame_q.push_back('{owm_pkg::ASCII_ZERO + 6'((u / 10) % 10), 1'b0});
      frame_q.push_back('{owm_pkg::ASCII_ZERO + 6'(u % 10), k == 2});
    end
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    int hv;
    if (!rst_n) begin
      gyro_p <= 12'd128;
      gyro_d <= 12'd384;
      cam_p <= 12'd422;
      cam_d <= 12'd538;
      prev_dev = 0;
      correction = 0;
      frame_q.delete();
      errors <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          owm_pkg::REG_GYRO_P: gyro_p <= cfg_ch.data;
          owm_pkg::REG_GYRO_D: gyro_d <= cfg_ch.data;
          owm_pkg::REG_CAM_P: cam_p <= cfg_ch.data;
          owm_pkg::REG_CAM_D: cam_d <= cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        hv = int'(in_ch.heading_value);
        case (in_ch.kind)
          owm_pkg::KIND_GYRO: correction = heading_pd(hv, gyro_p, gyro_d);
          owm_pkg::KIND_CAM: begin
            if (hv >= 90) hv -= 180;
            correction = heading_pd(hv,
              in_ch.p_gain_override != 0 ? int'(in_ch.p_gain_override) : int'(cam_p),
              in_ch.d_gain_override != 0 ? int'(in_ch.d_gain_override) : int'(cam_d));
          end
          owm_pkg::KIND_MOVE: mix_wheels(int'(in_ch.move_direction), int'(in_ch.move_power));
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (frame_q.size() == 0) begin
          $display("%0t: unexpected byte actual %0d last %0b", $time,
            out_ch.frame_byte, out_ch.last_byte);
          errors <= errors + 1;
        end else begin
          want = frame_q.pop_front();
          if (want.frame_byte !== out_ch.frame_byte || want.last_byte !== out_ch.last_byte) begin
            $display("%0t: byte mismatch expected %0d last %0b actual %0d last %0b", $time,
              want.frame_byte, want.last_byte, out_ch.frame_byte, out_ch.last_byte);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= frame_q.size();
  end

  final begin
    if (frame_q.size() != 0) $display("%0t: %0d bytes never arrived", $time, frame_q.size());
  end
endmodule

@@ test/omni_wheel_mixer_pd_heading_tb.sv @@
`timescale 1ns / 1ps
module omni_wheel_mixer_pd_heading_tb;
  logic clk;
  logic rst_n;
  int errors;
  int pending;

  owm_in_if in_ch();
  owm_out_if out_ch();
  owm_cfg_if cfg_ch();

  omni_wheel_mixer_pd_heading dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  owm_frame_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic [1:0] kind, int hv, int pg, int dg, int dir, int pw);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.heading_value <= hv[9:0];
    in_ch.p_gain_override <= pg[11:0];
    in_ch.d_gain_override <= dg[11:0];
    in_ch.move_direction <= dir[8:0];
    in_ch.move_power <= pw[7:0];
    do @(posedge clk); while (!in_ch.ready);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [owm_pkg::CFG_IDX_W-1:0] idx, int val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val[11:0];
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_item();
    int r, pw;
    r = $urandom_range(0, 99);
    pw = ($urandom_range(0, 9) == 0) ? int'($signed(8'($urandom))) : $urandom_range(0, 200) - 100;
    if (r < 45)
      send_item(owm_pkg::KIND_MOVE, $urandom, $urandom, $urandom,
        ($urandom_range(0, 9) == 0) ? $urandom_range(360, 511) : $urandom_range(0, 359), pw);
    else if (r < 70)
      send_item(owm_pkg::KIND_GYRO, $urandom, $urandom, $urandom, $urandom, $urandom);
    else if (r < 95)
      send_item(owm_pkg::KIND_CAM, $urandom,
        ($urandom_range(0, 2) == 0) ? 0 : $urandom,
        ($urandom_range(0, 2) == 0) ? 0 : $urandom, $urandom, $urandom);
    else
      send_item(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // receiver: one long hold-off at the start, then random stalls
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    repeat (250) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      @(posedge clk);
      gap = ($urandom_range(0, 59) == 0) ? $urandom_range(150, 300) : pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.kind <= owm_pkg::KIND_GYRO;
    in_ch.heading_value <= '0;
    in_ch.p_gain_override <= '0;
    in_ch.d_gain_override <= '0;
    in_ch.move_direction <= '0;
    in_ch.move_power <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= owm_pkg::REG_GYRO_P;
    cfg_ch.data <= '0;
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(owm_pkg::KIND_MOVE, 0, 0, 0, 0, 0);
    send_item(owm_pkg::KIND_GYRO, 511, 0, 0, 0, 0);
    send_item(owm_pkg::KIND_MOVE, 0, 0, 0, 90, 100);
    send_item(owm_pkg::KIND_GYRO, -512, 0, 0, 0, 0);
    send_item(owm_pkg::KIND_MOVE, 0, 0, 0, 359, -100);
    send_item(owm_pkg::KIND_CAM, 89, 0, 0, 0, 0);
    send_item(owm_pkg::KIND_MOVE, 0, 0, 0, 360, 127);
    send_item(owm_pkg::KIND_CAM, 90, 4095, 4095, 0, 0);
    send_item(owm_pkg::KIND_MOVE, 0, 0, 0, 511, -128);
    send_item(owm_pkg::KIND_CAM, 511, 0, 4095, 0, 0);
    send_item(owm_pkg::KIND_CAM, -512, 4095, 0, 0, 0);
    send_item(owm_pkg::KIND_MOVE, 0, 0, 0, 180, 1);
    send_item(2'd3, 100, 7, 7, 30, 50);
    send_item(owm_pkg::KIND_GYRO, 0, 0, 0, 0, 0);
    send_item(owm_pkg::KIND_GYRO, 0, 0, 0, 0, 0);
    send_item(owm_pkg::KIND_MOVE, 0, 0, 0, 45, 50);
    send_item(owm_pkg::KIND_MOVE, 0, 0, 0, 270, -1);

    for (int ph = 0; ph < 3; ph++) begin
      wait_idle();
      for (int i = 0; i < 4; i++)
        write_reg(i[1:0], ph == 0 ? 4095 : ph == 1 ? 0 : $urandom_range(0, 4095));
      cfg_ch.valid <= 1'b0;
      repeat (64) random_item();
    end
    wait_idle();
    if (errors == 0) $display("PASS omni_wheel_mixer_pd_heading");
    else $display("FAIL omni_wheel_mixer_pd_heading");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("FAIL omni_wheel_mixer_pd_heading");
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/owm_pkg.sv
rtl/core/owm_if.sv
rtl/core/owm_ctrl.sv
rtl/core/owm_dp.sv
rtl/core/omni_wheel_mixer_pd_heading.sv
test/owm_frame_checker.sv
test/omni_wheel_mixer_pd_heading_tb.sv
